// ===== hw/rtl/display_slot_rotator_defines.svh =====
// Assertion macros shared by the display slot rotator RTL.
`ifndef DISPLAY_SLOT_ROTATOR_DEFINES_SVH
`define DISPLAY_SLOT_ROTATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/dsr_pkg.sv =====
// Types, constants and codes shared by the display slot rotator.
`default_nettype none

package dsr_pkg;

	localparam int unsigned MAX_SLOTS_DEF = 16;
	localparam int unsigned CNT_W         = 5;
	localparam int unsigned MASK_W        = 16;
	localparam int unsigned MASK_IDX_W    = 4;
	localparam int unsigned TIME_W        = 24;
	localparam int unsigned STAMP_W       = 32;
	localparam int unsigned OUT_SLOT_W    = 4;
	localparam int unsigned CMD_W         = 3;
	localparam int unsigned CFG_ADDR_W    = 5;
	localparam int unsigned CFG_DATA_W    = 32;

	localparam logic [CNT_W-1:0]  APP_COUNT_RST     = '0;
	localparam logic [MASK_W-1:0] ENABLE_MASK_RST   = 16'hFFFF;
	localparam logic [TIME_W-1:0] DWELL_MS_RST      = 24'd10000;
	localparam logic [TIME_W-1:0] TRANSITION_MS_RST = 24'd500;
	localparam logic              AUTO_ROTATE_RST   = 1'b1;

	typedef enum logic [CFG_ADDR_W-3:0] {
		REG_APP_COUNT     = 3'd0,
		REG_ENABLE_MASK   = 3'd1,
		REG_DWELL_MS      = 3'd2,
		REG_TRANSITION_MS = 3'd3,
		REG_AUTO_ROTATE   = 3'd4
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 3'd0,
		CMD_NEXT   = 3'd1,
		CMD_PREV   = 3'd2,
		CMD_SWITCH = 3'd3,
		CMD_XFER   = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MOD,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]      cmd;
		logic [STAMP_W-1:0]    now_ms;
		logic [OUT_SLOT_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic [OUT_SLOT_W-1:0] current_slot;
		logic                  current_valid;
		logic                  in_transition;
		logic [OUT_SLOT_W-1:0] incoming_slot;
		logic                  accepted;
	} rsp_t;

	typedef struct packed {
		logic [CNT_W-1:0]  app_count;
		logic [MASK_W-1:0] enable_mask;
		logic [TIME_W-1:0] dwell_ms;
		logic [TIME_W-1:0] transition_ms;
		logic              auto_rotate;
	} cfg_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic reduce;
		logic scan_start;
		logic scan_next;
		logic commit;
		logic rsp_load;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic need_scan;
		logic base_ok;
		logic hit;
		logic last;
		logic cur_ok;
	} dp_st_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dsr_stream_if.sv =====
// Valid/ready stream interface carrying one payload beat.
`default_nettype none

interface dsr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dsr_regs.sv =====
// APB configuration registers of the display slot rotator.
`default_nettype none

module dsr_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dsr_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [dsr_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [dsr_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready,
	output dsr_pkg::cfg_t                   cfg
);
	import dsr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.app_count     <= APP_COUNT_RST;
			cfg_q.enable_mask   <= ENABLE_MASK_RST;
			cfg_q.dwell_ms      <= DWELL_MS_RST;
			cfg_q.transition_ms <= TRANSITION_MS_RST;
			cfg_q.auto_rotate   <= AUTO_ROTATE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_APP_COUNT:     cfg_q.app_count     <= pwdata[CNT_W-1:0];
				REG_ENABLE_MASK:   cfg_q.enable_mask   <= pwdata[MASK_W-1:0];
				REG_DWELL_MS:      cfg_q.dwell_ms      <= pwdata[TIME_W-1:0];
				REG_TRANSITION_MS: cfg_q.transition_ms <= pwdata[TIME_W-1:0];
				REG_AUTO_ROTATE:   cfg_q.auto_rotate   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_APP_COUNT:     prdata = CFG_DATA_W'(cfg_q.app_count);
			REG_ENABLE_MASK:   prdata = CFG_DATA_W'(cfg_q.enable_mask);
			REG_DWELL_MS:      prdata = CFG_DATA_W'(cfg_q.dwell_ms);
			REG_TRANSITION_MS: prdata = CFG_DATA_W'(cfg_q.transition_ms);
			REG_AUTO_ROTATE:   prdata = CFG_DATA_W'(cfg_q.auto_rotate);
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dsr_ctrl.sv =====
// Sequencing state machine of the display slot rotator.
`default_nettype none

module dsr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  dsr_pkg::dp_st_t  st,
	output dsr_pkg::dp_cmd_t cmd
);
	import dsr_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = st.need_scan ? ST_MOD : ST_DONE;
			end
			ST_MOD: begin
				if (st.base_ok) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (st.hit || st.last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_MOD: begin
				cmd.scan_start = st.base_ok;
				cmd.reduce     = !st.base_ok;
			end
			ST_SCAN: begin
				cmd.commit    = st.hit;
				cmd.scan_next = !st.hit && !st.last;
			end
			ST_DONE: begin
				cmd.rsp_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rsp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dsr_dp.sv =====
// Rotation state, command decode and slot search datapath.
`default_nettype none

module dsr_dp #(
	parameter int unsigned MAX_SLOTS = dsr_pkg::MAX_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dsr_pkg::cfg_t    cfg,
	input  dsr_pkg::dp_cmd_t cmd,
	input  dsr_pkg::req_t    req,
	output dsr_pkg::dp_st_t  st,
	output dsr_pkg::rsp_t    rsp
);
	import dsr_pkg::*;

	localparam int unsigned SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int unsigned CMP_W  = (SLOT_W > CNT_W) ? SLOT_W + 1 : CNT_W + 1;

	// latched command beat
	logic [CMD_W-1:0]      cmd_q;
	logic [STAMP_W-1:0]    now_q;
	logic [OUT_SLOT_W-1:0] idx_q;

	// rotation state
	logic                  phase_q;
	logic [SLOT_W-1:0]     shown_q;
	logic [SLOT_W-1:0]     target_q;
	logic                  tv_q;
	logic                  dir_q;
	logic [STAMP_W-1:0]    start_q;
	logic                  cs_q;

	// search
	logic [SLOT_W-1:0]     base_q;
	logic [SLOT_W-1:0]     cur_q;
	logic [CNT_W-1:0]      step_q;
	logic                  back_q;
	logic                  acc_q;
	rsp_t                  rsp_q;

	logic [CNT_W-1:0]      n;
	logic [CMP_W-1:0]      n_w;
	logic [STAMP_W-1:0]    elapsed;
	logic [SLOT_W-1:0]     settled_shown;
	logic                  idx_ok;
	logic                  same_target;
	logic                  idx_is_shown;
	logic                  do_settle;
	logic                  do_begin;
	logic                  do_switch;
	logic                  do_xfer;
	logic                  tick_start;
	logic                  settle_now;
	logic                  restart;
	logic                  back_d;
	logic                  acc_d;
	logic [SLOT_W-1:0]     cur_src;
	logic [SLOT_W-1:0]     cur_nx;

	// effective slot count: app_count clipped to the slot capacity
	assign n   = (CMP_W'(cfg.app_count) > CMP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
	                                                       : cfg.app_count;
	assign n_w = CMP_W'(n);

	assign elapsed       = now_q - (cs_q ? start_q : now_q);
	assign settled_shown = (phase_q && tv_q && (CMP_W'(target_q) < n_w)) ? target_q : shown_q;
	assign idx_ok        = CMP_W'(idx_q) < n_w;
	assign same_target   = phase_q && tv_q && (CMP_W'(idx_q) == CMP_W'(target_q));
	assign idx_is_shown  = CMP_W'(idx_q) == CMP_W'(settled_shown);

	always_comb begin
		do_settle  = 1'b0;
		do_begin   = 1'b0;
		do_switch  = 1'b0;
		do_xfer    = 1'b0;
		tick_start = 1'b0;
		acc_d      = 1'b0;
		back_d     = dir_q;
		case (cmd_q)
			CMD_TICK: begin
				if (n != '0) begin
					tick_start = !cs_q;
					if (!phase_q) begin
						do_begin = cfg.auto_rotate && (n_w >= CMP_W'(2)) &&
						           (elapsed >= STAMP_W'(cfg.dwell_ms));
					end else begin
						do_settle = elapsed >= STAMP_W'(cfg.transition_ms);
					end
				end
			end
			CMD_NEXT: begin
				do_begin = n_w >= CMP_W'(2);
				back_d   = 1'b0;
			end
			CMD_PREV: begin
				do_begin = n_w >= CMP_W'(2);
				back_d   = 1'b1;
			end
			CMD_SWITCH: begin
				do_switch = idx_ok;
				acc_d     = idx_ok;
			end
			CMD_XFER: begin
				acc_d     = idx_ok;
				do_settle = idx_ok && !same_target;
				do_xfer   = idx_ok && !same_target && !idx_is_shown;
			end
			default: ;
		endcase
	end

	// a settle, or a begin, only acts on a running transition
	assign settle_now = (do_settle || do_begin) && phase_q;

	// every state change restarts the phase clock at the beat's timestamp
	assign restart = tick_start || settle_now || do_begin || do_switch || do_xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			shown_q  <= '0;
			target_q <= '0;
			tv_q     <= 1'b0;
			dir_q    <= 1'b0;
			start_q  <= '0;
			cs_q     <= 1'b0;
		end else begin
			if (cmd.exec) begin
				if (restart) begin
					start_q <= now_q;
					cs_q    <= 1'b1;
				end
				if (do_switch) begin
					shown_q <= SLOT_W'(idx_q);
				end else if (settle_now) begin
					shown_q <= settled_shown;
				end
				if (do_xfer) begin
					tv_q <= 1'b1;
				end else if (settle_now || do_switch) begin
					tv_q <= 1'b0;
				end
				if (settle_now || do_xfer) begin
					dir_q <= 1'b0;
				end
				// xfer or a scan hit starts a transition; others restart fixed phase
				if (do_xfer) begin
					phase_q <= 1'b1;
				end else if (settle_now || do_begin || do_switch) begin
					phase_q <= 1'b0;
				end
				if (do_xfer) begin
					target_q <= SLOT_W'(idx_q);
				end
			end
			if (cmd.commit) begin
				dir_q    <= back_q;
				target_q <= cur_q;
				tv_q     <= 1'b1;
				phase_q  <= 1'b1;
			end
		end
	end

	// step the cursor one slot around the ring
	assign cur_src = cmd.scan_start ? base_q : cur_q;

	always_comb begin
		if (back_q) begin
			cur_nx = (cur_src == '0) ? SLOT_W'(n_w - CMP_W'(1)) : cur_src - 1'b1;
		end else begin
			cur_nx = (CMP_W'(cur_src) == n_w - CMP_W'(1)) ? '0 : cur_src + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= req.cmd;
			now_q <= req.now_ms;
			idx_q <= req.slot_index;
		end
		if (cmd.exec) begin
			base_q <= settled_shown;
			back_q <= back_d;
			acc_q  <= acc_d;
		end
		if (cmd.reduce) begin
			base_q <= base_q - SLOT_W'(n);
		end
		if (cmd.scan_start || cmd.scan_next) begin
			cur_q  <= cur_nx;
			step_q <= cmd.scan_start ? CNT_W'(1) : step_q + 1'b1;
		end
		if (cmd.rsp_load) begin
			rsp_q.current_slot  <= OUT_SLOT_W'(shown_q);
			rsp_q.current_valid <= CMP_W'(shown_q) < n_w;
			rsp_q.in_transition <= phase_q;
			rsp_q.incoming_slot <= phase_q ? OUT_SLOT_W'(target_q) : '0;
			rsp_q.accepted      <= acc_q;
		end
	end

	assign st.need_scan = do_begin;
	assign st.base_ok   = CMP_W'(base_q) < n_w;
	assign st.hit       = (CMP_W'(cur_q) >= CMP_W'(MASK_W)) ||
	                      cfg.enable_mask[MASK_IDX_W'(cur_q)];
	assign st.last      = CMP_W'(step_q) == n_w - CMP_W'(1);
	assign st.cur_ok    = CMP_W'(cur_q) < n_w;

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/display_slot_rotator.sv =====
// Display slot rotator top level: config registers, controller and datapath.
// Rotates a display among the first app_count slots (clipped to MAX_SLOTS).
// Each command beat on the request stream (tick with a millisecond timestamp,
// next, previous, switch to a slot, transition to a slot) yields exactly one
// result beat with the shown slot, its validity, the transition flag, the
// incoming slot and whether a slot request was accepted. Commands are handled
// one at a time: a beat is taken in idle, then decoded and applied, and its
// result is loaded into the output register once that register is free.
// A command that starts a rotation (next, previous, or a tick whose dwell
// expired) also runs the slot search: it reduces the start slot into range,
// repeating the reduction while the shown slot is stale beyond a shrunken
// count, then probes slots around the ring until one hits or the last step
// is reached. The search unit probes one slot per cycle.
// The result register lets the next command enter while a result waits; a
// result stalls the controller only if the previous one is still not taken.
// Elapsed time is the 32-bit wrap-around difference of timestamps. The APB
// port holds app_count, enable_mask, dwell_ms, transition_ms and auto_rotate
// at byte addresses 0, 4, 8, 12, 16; write them only while the block is idle.
`default_nettype none
`include "display_slot_rotator_defines.svh"

module display_slot_rotator #(
	parameter int unsigned MAX_SLOTS = dsr_pkg::MAX_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dsr_stream_if.sink                     request,
	dsr_stream_if.source                   result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dsr_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [dsr_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [dsr_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);
	import dsr_pkg::*;

	cfg_t    cfg;
	dp_cmd_t dp_cmd;
	dp_st_t  dp_st;
	req_t    req_beat;
	rsp_t    rsp_beat;

	assign req_beat.cmd        = request.data.cmd;
	assign req_beat.now_ms     = request.data.now_ms;
	assign req_beat.slot_index = request.data.slot_index;

	// Configuration registers.
	dsr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer: accept, decode/apply, search, load result.
	dsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.st        (dp_st),
		.cmd       (dp_cmd)
	);

	// Rotation state and slot search.
	dsr_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (dp_cmd),
		.req    (req_beat),
		.st     (dp_st),
		.rsp    (rsp_beat)
	);

	assign result.data.current_slot  = rsp_beat.current_slot;
	assign result.data.current_valid = rsp_beat.current_valid;
	assign result.data.in_transition = rsp_beat.in_transition;
	assign result.data.incoming_slot = rsp_beat.incoming_slot;
	assign result.data.accepted      = rsp_beat.accepted;

	// Only one command in flight: ready drops right after a beat is taken.
	`DSR_ASSERT_NEXT(a_one_in_flight, request.valid && request.ready, !request.ready, "second beat taken while busy")
	// The search cursor never leaves the active slot range.
	`DSR_ASSERT_NOW(a_scan_in_range, dp_cmd.scan_next || dp_cmd.commit, dp_st.cur_ok, "search cursor out of range")
	// Without a transition the incoming slot reads zero.
	`DSR_ASSERT_NOW(a_incoming_idle, result.valid && !result.data.in_transition, result.data.incoming_slot == '0, "incoming slot set while fixed")

endmodule

`default_nettype wire
